// ----- hw/rtl/dec_hex_number_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the decimal / hex number parser
// Shared concurrent-assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef DEC_HEX_NUMBER_PARSER_DEFINES_SVH
`define DEC_HEX_NUMBER_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DHP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhp assertion failed");

`endif

// ----- hw/rtl/dhp_pkg.sv -----
// ----------------------------------------------------------------------------
// dhp_pkg
// Word types, phase and status codes and character constants of the parser.
// ----------------------------------------------------------------------------
package dhp_pkg;

  typedef struct packed {
    logic       start_req;
    logic [7:0] char_code;
  } char_word_t;

  typedef struct packed {
    logic [31:0] number;
    logic [7:0]  consumed;
    logic [1:0]  status;
  } result_word_t;

  // Result from the parse core toward the result register
  typedef struct packed {
    logic         emit;
    result_word_t word;
  } core_res_t;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_HEXPRE = 3'd3;
  localparam logic [2:0] PH_HEX    = 3'd4;
  localparam logic [2:0] PH_DEC    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NODIGITS = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;

  localparam logic [3:0]  HEX_LETTER_OFFSET = 4'd9;
  localparam logic [31:0] DEC_LIMIT         = 32'd429496729;
  localparam logic [3:0]  DEC_LAST_DIGIT    = 4'd5;
  localparam logic [7:0]  CNT_MAX           = 8'd255;

endpackage

// ----- hw/rtl/dhp_in_reg.sv -----
// ----------------------------------------------------------------------------
// dhp_in_reg
// Input register: holds one character word until the core takes it.
// ----------------------------------------------------------------------------
module dhp_in_reg import dhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  char_word_t char_word,
  input  logic       pop,
  output logic       held_valid,
  output char_word_t held_word
);

  assign char_ready = !held_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (char_valid && char_ready) begin
      held_valid <= 1'b1;
    end else if (pop) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      held_word <= char_word;
    end
  end

endmodule

// ----- hw/rtl/dhp_core.sv -----
// ----------------------------------------------------------------------------
// dhp_core
// Parse state and one-character step: phase, accumulator and count.
// ----------------------------------------------------------------------------
`include "dec_hex_number_parser_defines.svh"

module dhp_core import dhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  char_word_t word,
  output core_res_t  res
);

  logic [2:0]  phase;
  logic [31:0] accumulator;
  logic [7:0]  char_count;

  logic [2:0]  phase_next;
  logic [31:0] accumulator_next;
  logic [7:0]  char_count_next;

  logic [2:0]  ph_eff;
  logic [31:0] acc_eff;
  logic [7:0]  cnt_eff;
  logic [7:0]  cnt_inc;
  logic [7:0]  c;
  logic        is_dec;
  logic        is_hex_lo;
  logic        is_hex_up;
  logic        is_hex;
  logic [3:0]  dec_d;
  logic [3:0]  hex_d;
  logic        dec_ovf;
  logic        hex_ovf;
  logic [31:0] acc_dec;
  logic [31:0] acc_hex;

  // A start word restarts the parse before the character is looked at
  assign ph_eff  = word.start_req ? PH_SPACE : phase;
  assign acc_eff = word.start_req ? 32'd0 : accumulator;
  assign cnt_eff = word.start_req ? 8'd0 : char_count;
  assign cnt_inc = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + 8'd1;

  assign c         = word.char_code;
  assign is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_hex_lo = (c >= CH_A_LO) && (c <= CH_F_LO);
  assign is_hex_up = (c >= CH_A_UP) && (c <= CH_F_UP);
  assign is_hex    = is_dec || is_hex_lo || is_hex_up;
  assign dec_d     = c[3:0];
  assign hex_d     = is_dec ? c[3:0] : c[3:0] + HEX_LETTER_OFFSET;

  assign dec_ovf = (acc_eff > DEC_LIMIT) || ((acc_eff == DEC_LIMIT) && (dec_d > DEC_LAST_DIGIT));
  assign hex_ovf = (acc_eff[31:28] != 4'd0);

  // times ten as 8x + 2x, then add the digit
  assign acc_dec = {acc_eff[28:0], 3'b000} + {acc_eff[30:0], 1'b0} + {28'd0, dec_d};
  assign acc_hex = {acc_eff[27:0], hex_d};

  always_comb begin
    phase_next        = ph_eff;
    accumulator_next  = acc_eff;
    char_count_next   = cnt_eff;
    res.emit          = 1'b0;
    res.word.number   = 32'd0;
    res.word.consumed = cnt_eff;
    res.word.status   = ST_OK;
    unique case (ph_eff)
      PH_SPACE: begin
        if (c == CH_SPACE) begin
          char_count_next = cnt_inc;
        end else if (c == CH_ZERO) begin
          accumulator_next = 32'd0;
          char_count_next  = cnt_inc;
          phase_next       = PH_ZERO;
        end else if (is_dec) begin
          accumulator_next = {28'd0, dec_d};
          char_count_next  = cnt_inc;
          phase_next       = PH_DEC;
        end else begin
          res.emit        = 1'b1;
          res.word.status = ST_NODIGITS;
        end
      end
      PH_ZERO, PH_DEC: begin
        if ((ph_eff == PH_ZERO) && ((c == CH_X_LO) || (c == CH_X_UP))) begin
          accumulator_next = 32'd0;
          char_count_next  = cnt_inc;
          phase_next       = PH_HEXPRE;
        end else if (!is_dec) begin
          res.emit        = 1'b1;
          res.word.number = acc_eff;
        end else if (dec_ovf) begin
          res.emit        = 1'b1;
          res.word.status = ST_OVERFLOW;
        end else begin
          accumulator_next = acc_dec;
          char_count_next  = cnt_inc;
          phase_next       = PH_DEC;
        end
      end
      PH_HEXPRE, PH_HEX: begin
        if (!is_hex) begin
          res.emit = 1'b1;
          if (ph_eff == PH_HEXPRE) begin
            res.word.status = ST_NODIGITS;
          end else begin
            res.word.number = acc_eff;
          end
        end else if (hex_ovf) begin
          res.emit        = 1'b1;
          res.word.status = ST_OVERFLOW;
        end else begin
          accumulator_next = acc_hex;
          char_count_next  = cnt_inc;
          phase_next       = PH_HEX;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    // a result always ends the string
    if (res.emit) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      accumulator <= 32'd0;
      char_count  <= 8'd0;
    end else if (adv) begin
      phase       <= phase_next;
      accumulator <= accumulator_next;
      char_count  <= char_count_next;
    end
  end

  `DHP_ASSERT_NEXT(a_emit_goes_idle, clk, rst, adv && res.emit, phase == PH_IDLE)
  `DHP_ASSERT_NOW(a_error_number_zero, clk, rst, res.emit && (res.word.status != ST_OK), res.word.number == 32'd0)
  `DHP_ASSERT_NEXT(a_count_saturates, clk, rst, adv && !word.start_req && (char_count == CNT_MAX), char_count == CNT_MAX)

endmodule

// ----- hw/rtl/dhp_out_reg.sv -----
// ----------------------------------------------------------------------------
// dhp_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module dhp_out_reg import dhp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  result_word_t load_word,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result_word
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word <= load_word;
    end
  end

endmodule

// ----- hw/rtl/dec_hex_number_parser.sv -----
// ----------------------------------------------------------------------------
// dec_hex_number_parser
// Streaming ASCII decimal / 0x-hex parser to a 32-bit unsigned value.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                   | word
//  char     | in  | char_valid / char_ready     | char_word   (start_req, char_code)
//  result   | out | result_valid / result_ready | result_word (number, consumed, status)
//
//  One character per cycle sustained while the core is not stalled; a result is
//  loaded into the result register as the core steps its terminating character.
//  The cycle is set by the step logic: times-ten shift-add and range compare.
//  Synchronous reset puts the parser in idle; no clearing pass is needed.
//  A held result stalls the core; one more character waits in the input register.
// ----------------------------------------------------------------------------
module dec_hex_number_parser import dhp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_ready,
  input  char_word_t   char_word,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result_word
);

  logic       held_valid;
  char_word_t held_word;
  logic       adv;
  core_res_t  res;

  // advance the held character when the result register can take a result
  assign adv = held_valid && (!result_valid || result_ready);

  dhp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_word  (char_word),
    .pop        (adv),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  dhp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .word (held_word),
    .res  (res)
  );

  dhp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (adv && res.emit),
    .load_word    (res.word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

endmodule
